@@ sv/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the two-square split block
// Widths, status codes, datapath operation codes and the command/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int PRIME_W   = 32;
    localparam int ROOT_W    = 16;
    localparam int TRY_W     = 16;
    localparam int CNT_W     = 5;
    localparam int SQRT_STEPS = PRIME_W / 2;
    localparam logic [TRY_W-1:0] MAX_TRIES_RESET = TRY_W'(256);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RESIDUE = 2'd1,
        ST_NO_NQR  = 2'd2,
        ST_CHECK   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_POW_HALF,
        DP_POW_QTR,
        DP_MUL_AB,
        DP_MUL_BB,
        DP_MUL_STEP,
        DP_WB_ACC,
        DP_WB_BASE,
        DP_NEXT_U,
        DP_SET_X,
        DP_SQRT_P,
        DP_SQRT_R,
        DP_SQRT_STEP,
        DP_WB_IP,
        DP_WB_B,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_WB,
        DP_SQ_A,
        DP_SQ_B,
        DP_OUT_OK,
        DP_OUT_RES,
        DP_OUT_NQR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic res_ok;
        logic tries_left;
        logic e_zero;
        logic e_lsb;
        logic cnt_last;
        logic found;
        logic lo_gt_ip;
    } dp_status_t;

endpackage

`default_nettype wire

@@ sv/prime_two_square_split.sv @@
// ----------------------------------------------------------------------------
// prime_two_square_split: splits a prime p = 1 mod 4 into a*a + b*b
// A wrong residue is answered straight after the residue check; otherwise the
// run time grows with the candidates tried and the Euclid steps, and is set
// by the serial modular multiplier, used once or twice per exponent bit.
// Throughput: one word at a time; start is taken only while busy is low.
// The receiver cannot stall: done pulses for one cycle with the result.
// Reset (rst_n, async, active low) returns to idle and max_tries to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_two_square_split (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pts_pkg::PRIME_W-1:0]  prime,
    output logic                              busy,
    output logic                              done,
    output logic [pts_pkg::ROOT_W-1:0]        first_root,
    output logic [pts_pkg::ROOT_W-1:0]        second_root,
    output logic [1:0]                        status,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pts_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       stat;
    logic [TRY_W-1:0] max_tries_reg, max_tries_next;
    logic             cfg_wr;

    // write max_tries on the access phase of an APB write
    assign pready         = 1'b1;
    assign cfg_wr         = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign max_tries_next = cfg_wr ? pwdata[TRY_W-1:0] : max_tries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_tries_reg <= MAX_TRIES_RESET;
        else
            max_tries_reg <= max_tries_next;
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-TRY_W){1'b0}}, max_tries_reg} : '0;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pts_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .prime       (prime),
        .max_tries   (max_tries_reg),
        .stat        (stat),
        .first_root  (first_root),
        .second_root (second_root),
        .status      (status)
    );

endmodule

`default_nettype wire

@@ sv/pts_dp.sv @@
// ----------------------------------------------------------------------------
// pts_dp: datapath of the two-square split block
// Serial modular multiplier, restoring divider, bit-pair square root and a
// 16x16 squarer, each stepped one operation per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_dp (
    input  wire logic                         clk,
    input  wire pts_pkg::dp_cmd_t             cmd,
    input  wire logic [pts_pkg::PRIME_W-1:0]  prime,
    input  wire logic [pts_pkg::TRY_W-1:0]    max_tries,
    output pts_pkg::dp_status_t               stat,
    output logic [pts_pkg::ROOT_W-1:0]        first_root,
    output logic [pts_pkg::ROOT_W-1:0]        second_root,
    output logic [1:0]                        status
);
    import pts_pkg::*;

    logic [PRIME_W-1:0] p_reg, p_next;
    logic [PRIME_W-1:0] u_reg, u_next;
    logic [TRY_W-1:0]   t_reg, t_next;
    logic [PRIME_W-1:0] acc_reg, acc_next;
    logic [PRIME_W-1:0] base_reg, base_next;
    logic [PRIME_W-1:0] e_reg, e_next;
    logic [PRIME_W-1:0] mx_reg, mx_next;
    logic [PRIME_W-1:0] my_reg, my_next;
    logic [PRIME_W-1:0] macc_reg, macc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PRIME_W-1:0] hi_reg, hi_next;
    logic [PRIME_W-1:0] lo_reg, lo_next;
    logic [PRIME_W-1:0] rem_reg, rem_next;
    logic [PRIME_W-1:0] sv_reg, sv_next;
    logic [PRIME_W-1:0] sres_reg, sres_next;
    logic [PRIME_W-1:0] sbit_reg, sbit_next;
    logic [ROOT_W-1:0]  ip_reg, ip_next;
    logic [ROOT_W-1:0]  a_reg, a_next;
    logic [ROOT_W-1:0]  b_reg, b_next;
    logic [PRIME_W-1:0] asq_reg, asq_next;
    logic [PRIME_W-1:0] bsq_reg, bsq_next;
    logic [ROOT_W-1:0]  ra_reg, ra_next;
    logic [ROOT_W-1:0]  rb_reg, rb_next;
    logic [1:0]         rs_reg, rs_next;

    logic               p_is_one;
    logic [PRIME_W:0]   dbl, dbl_red, addv, addv_red;
    logic [PRIME_W:0]   dshift;
    logic [PRIME_W:0]   strial;
    logic [PRIME_W-1:0] u_inc;
    logic [PRIME_W-1:0] neg_r;
    logic [PRIME_W:0]   sq_sum;
    logic               check_ok;

    assign p_is_one = (p_reg == PRIME_W'(1));

    // modular double-and-add step of the serial multiplier
    always_comb
    begin
        dbl      = {macc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, p_reg}) ? dbl - {1'b0, p_reg} : dbl;
        addv     = dbl_red + {1'b0, mx_reg};
        addv_red = (addv >= {1'b0, p_reg}) ? addv - {1'b0, p_reg} : addv;
    end

    // restoring divider and square root trial values
    assign dshift = {rem_reg, hi_reg[cnt_reg]};
    assign strial = {1'b0, sres_reg} + {1'b0, sbit_reg};

    assign u_inc    = u_reg + PRIME_W'(1);
    assign neg_r    = p_reg - acc_reg;
    assign sq_sum   = {1'b0, asq_reg} + {1'b0, bsq_reg};
    assign check_ok = (sq_sum == {1'b0, p_reg});

    // status to the controller
    always_comb
    begin
        stat.res_ok     = (p_reg[1:0] == 2'b01);
        stat.tries_left = (t_reg < max_tries);
        stat.e_zero     = (e_reg == '0);
        stat.e_lsb      = e_reg[0];
        stat.cnt_last   = (cnt_reg == '0);
        stat.found      = p_is_one ||
                          ((u_reg != '0) && (acc_reg == p_reg - PRIME_W'(1)));
        stat.lo_gt_ip   = (lo_reg > {{(PRIME_W-ROOT_W){1'b0}}, ip_reg});
    end

    // decode the operation of this cycle
    always_comb
    begin
        p_next    = p_reg;    u_next    = u_reg;    t_next    = t_reg;
        acc_next  = acc_reg;  base_next = base_reg; e_next    = e_reg;
        mx_next   = mx_reg;   my_next   = my_reg;   macc_next = macc_reg;
        cnt_next  = cnt_reg;  hi_next   = hi_reg;   lo_next   = lo_reg;
        rem_next  = rem_reg;  sv_next   = sv_reg;   sres_next = sres_reg;
        sbit_next = sbit_reg; ip_next   = ip_reg;   a_next    = a_reg;
        b_next    = b_reg;    asq_next  = asq_reg;  bsq_next  = bsq_reg;
        ra_next   = ra_reg;   rb_next   = rb_reg;   rs_next   = rs_reg;
        case (cmd.op)
            DP_LOAD:
            begin
                p_next = prime;
                u_next = (prime == PRIME_W'(1)) ? '0 : PRIME_W'(2);
                t_next = '0;
            end
            DP_POW_HALF, DP_POW_QTR:
            begin
                acc_next  = p_is_one ? '0 : PRIME_W'(1);
                base_next = u_reg;
                e_next    = (cmd.op == DP_POW_HALF) ? (p_reg - PRIME_W'(1)) >> 1
                                                    : (p_reg - PRIME_W'(1)) >> 2;
            end
            DP_MUL_AB:
            begin
                mx_next   = acc_reg;
                my_next   = base_reg;
                macc_next = '0;
                cnt_next  = CNT_W'(PRIME_W - 1);
            end
            DP_MUL_BB:
            begin
                mx_next   = base_reg;
                my_next   = base_reg;
                macc_next = '0;
                cnt_next  = CNT_W'(PRIME_W - 1);
            end
            DP_MUL_STEP:
            begin
                macc_next = my_reg[cnt_reg] ? addv_red[PRIME_W-1:0]
                                            : dbl_red[PRIME_W-1:0];
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            DP_WB_ACC:
                acc_next = macc_reg;
            DP_WB_BASE:
            begin
                base_next = macc_reg;
                e_next    = e_reg >> 1;
            end
            DP_NEXT_U:
            begin
                u_next = (u_inc == p_reg) ? '0 : u_inc;
                t_next = t_reg + TRY_W'(1);
            end
            DP_SET_X:
            begin
                hi_next = p_reg;
                lo_next = (acc_reg > neg_r) ? acc_reg : neg_r;
            end
            DP_SQRT_P, DP_SQRT_R:
            begin
                sv_next   = (cmd.op == DP_SQRT_P) ? p_reg : p_reg - asq_reg;
                sres_next = '0;
                sbit_next = PRIME_W'(1) << (PRIME_W - 2);
                cnt_next  = CNT_W'(SQRT_STEPS - 1);
            end
            DP_SQRT_STEP:
            begin
                if ({1'b0, sv_reg} >= strial)
                begin
                    sv_next   = sv_reg - strial[PRIME_W-1:0];
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            DP_WB_IP:
                ip_next = sres_reg[ROOT_W-1:0];
            DP_WB_B:
                b_next = sres_reg[ROOT_W-1:0];
            DP_DIV_INIT:
            begin
                rem_next = '0;
                cnt_next = CNT_W'(PRIME_W - 1);
            end
            DP_DIV_STEP:
            begin
                rem_next = (dshift >= {1'b0, lo_reg})
                         ? PRIME_W'(dshift - {1'b0, lo_reg}) : dshift[PRIME_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_DIV_WB:
            begin
                hi_next = lo_reg;
                lo_next = rem_reg;
            end
            DP_SQ_A:
            begin
                a_next   = lo_reg[ROOT_W-1:0];
                asq_next = lo_reg[ROOT_W-1:0] * lo_reg[ROOT_W-1:0];
            end
            DP_SQ_B:
                bsq_next = b_reg * b_reg;
            DP_OUT_OK:
            begin
                ra_next = check_ok ? a_reg : '0;
                rb_next = check_ok ? b_reg : '0;
                rs_next = check_ok ? ST_OK : ST_CHECK;
            end
            DP_OUT_RES:
            begin
                ra_next = '0;
                rb_next = '0;
                rs_next = ST_RESIDUE;
            end
            DP_OUT_NQR:
            begin
                ra_next = '0;
                rb_next = '0;
                rs_next = ST_NO_NQR;
            end
            default:
            begin
            end
        endcase
    end

    // hold datapath registers
    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;    u_reg    <= u_next;    t_reg    <= t_next;
        acc_reg  <= acc_next;  base_reg <= base_next; e_reg    <= e_next;
        mx_reg   <= mx_next;   my_reg   <= my_next;   macc_reg <= macc_next;
        cnt_reg  <= cnt_next;  hi_reg   <= hi_next;   lo_reg   <= lo_next;
        rem_reg  <= rem_next;  sv_reg   <= sv_next;   sres_reg <= sres_next;
        sbit_reg <= sbit_next; ip_reg   <= ip_next;   a_reg    <= a_next;
        b_reg    <= b_next;    asq_reg  <= asq_next;  bsq_reg  <= bsq_next;
        ra_reg   <= ra_next;   rb_reg   <= rb_next;   rs_reg   <= rs_next;
    end

    assign first_root  = ra_reg;
    assign second_root = rb_reg;
    assign status      = rs_reg;

endmodule

`default_nettype wire

@@ sv/pts_ctrl.sv @@
// ----------------------------------------------------------------------------
// pts_ctrl: controller of the two-square split block
// Sequences the residue test, non-residue search, exponentiations, square
// roots and Euclid chain, issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire pts_pkg::dp_status_t  stat,
    output pts_pkg::dp_cmd_t          cmd,
    output logic                      busy,
    output logic                      done
);
    import pts_pkg::*;

    typedef enum logic [27:0] {
        S_IDLE    = 28'h0000001,
        S_RES_CHK = 28'h0000002,
        S_TRY_CHK = 28'h0000004,
        S_POW_INI = 28'h0000008,
        S_POW_CHK = 28'h0000010,
        S_AB_SET  = 28'h0000020,
        S_AB_RUN  = 28'h0000040,
        S_AB_WB   = 28'h0000080,
        S_BB_SET  = 28'h0000100,
        S_BB_RUN  = 28'h0000200,
        S_BB_WB   = 28'h0000400,
        S_EVAL    = 28'h0000800,
        S_NEXT_U  = 28'h0001000,
        S_SP_SET  = 28'h0002000,
        S_SP_RUN  = 28'h0004000,
        S_SP_WB   = 28'h0008000,
        S_EU_CHK  = 28'h0010000,
        S_DIV_SET = 28'h0020000,
        S_DIV_RUN = 28'h0040000,
        S_DIV_WB  = 28'h0080000,
        S_SQ_A    = 28'h0100000,
        S_SR_SET  = 28'h0200000,
        S_SR_RUN  = 28'h0400000,
        S_SR_WB   = 28'h0800000,
        S_SQ_B    = 28'h1000000,
        S_FIN_OK  = 28'h2000000,
        S_FIN_RES = 28'h4000000,
        S_FIN_NQR = 28'h8000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   done_reg, done_next;

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    phase_next = 1'b0;
                    state_next = S_RES_CHK;
                end
            S_RES_CHK:
                state_next = stat.res_ok ? S_TRY_CHK : S_FIN_RES;
            S_TRY_CHK:
                state_next = stat.tries_left ? S_POW_INI : S_FIN_NQR;
            S_POW_INI:
            begin
                cmd.op     = phase_reg ? DP_POW_QTR : DP_POW_HALF;
                state_next = S_POW_CHK;
            end
            S_POW_CHK:
                if (stat.e_zero)
                    state_next = S_EVAL;
                else
                    state_next = stat.e_lsb ? S_AB_SET : S_BB_SET;
            S_AB_SET:
            begin
                cmd.op     = DP_MUL_AB;
                state_next = S_AB_RUN;
            end
            S_AB_RUN:
            begin
                cmd.op = DP_MUL_STEP;
                if (stat.cnt_last)
                    state_next = S_AB_WB;
            end
            S_AB_WB:
            begin
                cmd.op     = DP_WB_ACC;
                state_next = S_BB_SET;
            end
            S_BB_SET:
            begin
                cmd.op     = DP_MUL_BB;
                state_next = S_BB_RUN;
            end
            S_BB_RUN:
            begin
                cmd.op = DP_MUL_STEP;
                if (stat.cnt_last)
                    state_next = S_BB_WB;
            end
            S_BB_WB:
            begin
                cmd.op     = DP_WB_BASE;
                state_next = S_POW_CHK;
            end
            S_EVAL:
                if (phase_reg)
                begin
                    cmd.op     = DP_SET_X;
                    state_next = S_SP_SET;
                end
                else if (stat.found)
                begin
                    phase_next = 1'b1;
                    state_next = S_POW_INI;
                end
                else
                begin
                    state_next = S_NEXT_U;
                end
            S_NEXT_U:
            begin
                cmd.op     = DP_NEXT_U;
                state_next = S_TRY_CHK;
            end
            S_SP_SET:
            begin
                cmd.op     = DP_SQRT_P;
                state_next = S_SP_RUN;
            end
            S_SP_RUN:
            begin
                cmd.op = DP_SQRT_STEP;
                if (stat.cnt_last)
                    state_next = S_SP_WB;
            end
            S_SP_WB:
            begin
                cmd.op     = DP_WB_IP;
                state_next = S_EU_CHK;
            end
            S_EU_CHK:
                state_next = stat.lo_gt_ip ? S_DIV_SET : S_SQ_A;
            S_DIV_SET:
            begin
                cmd.op     = DP_DIV_INIT;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.op = DP_DIV_STEP;
                if (stat.cnt_last)
                    state_next = S_DIV_WB;
            end
            S_DIV_WB:
            begin
                cmd.op     = DP_DIV_WB;
                state_next = S_EU_CHK;
            end
            S_SQ_A:
            begin
                cmd.op     = DP_SQ_A;
                state_next = S_SR_SET;
            end
            S_SR_SET:
            begin
                cmd.op     = DP_SQRT_R;
                state_next = S_SR_RUN;
            end
            S_SR_RUN:
            begin
                cmd.op = DP_SQRT_STEP;
                if (stat.cnt_last)
                    state_next = S_SR_WB;
            end
            S_SR_WB:
            begin
                cmd.op     = DP_WB_B;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                cmd.op     = DP_SQ_B;
                state_next = S_FIN_OK;
            end
            S_FIN_OK:
            begin
                cmd.op     = DP_OUT_OK;
                state_next = S_IDLE;
            end
            S_FIN_RES:
            begin
                cmd.op     = DP_OUT_RES;
                state_next = S_IDLE;
            end
            S_FIN_NQR:
            begin
                cmd.op     = DP_OUT_NQR;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // strobe the word in the same cycle as the result registers show it
    assign done_next = (state_reg == S_FIN_OK) || (state_reg == S_FIN_RES) ||
                       (state_reg == S_FIN_NQR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

@@ sv/pts_checker.sv @@
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the two-square split block
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [15:0] first_root,
    input  wire logic [15:0] second_root,
    input  wire logic [1:0]  status
);
    import pts_pkg::*;

    // accepted word makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // result shows only when idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // error results carry zero roots
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (first_root == '0) && (second_root == '0))
        else $error("nonzero roots on error status");

endmodule

bind prime_two_square_split pts_checker u_pts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .first_root  (first_root),
    .second_root (second_root),
    .status      (status)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: two-square split of primes
// Drives prime words through the start/busy handshake with random gaps and
// writes max_tries over APB between phases while the block is idle. A
// predictor computes each split, and a monitor checks every done word
// against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pts_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0] a;
        logic [ROOT_W-1:0] b;
        status_t           st;
    } split_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [PRIME_W-1:0]  prime;
    logic                busy;
    logic                done;
    logic [ROOT_W-1:0]   first_root;
    logic [ROOT_W-1:0]   second_root;
    logic [1:0]          status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    localparam logic [2:0] ADDR_MAX_TRIES = 3'd0;

    logic [PRIME_W-1:0]  pending_primes[$];
    split_t              expected_splits[$];
    logic [TRY_W-1:0]    tries_limit;
    int                  gap_left;
    int                  errors;

    prime_two_square_split dut (
        .clk(clk), .rst_n(rst_n), .start(start), .prime(prime), .busy(busy),
        .done(done), .first_root(first_root), .second_root(second_root),
        .status(status), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned pow_mod(longint unsigned base,
                                                longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * base) % m;
            base = (base * base) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic split_t predict_split(logic [PRIME_W-1:0] p_in);
        split_t          r;
        longint unsigned p, t, u, x, rr, ip, hi, lo, rem, a, b;
        bit              found;
        p     = p_in;
        r     = '{a: '0, b: '0, st: ST_OK};
        found = 0;
        x     = 0;
        if (p[1:0] != 2'b01)
        begin
            r.st = ST_RESIDUE;
            return r;
        end
        for (t = 0; t < tries_limit && !found; t++)
        begin
            u = (t + 2) % p;
            if ((u != 0 && pow_mod(u, (p - 1) >> 1, p) == p - 1) || p == 1)
            begin
                found = 1;
                rr = pow_mod(u, (p - 1) >> 2, p);
                x  = (rr > p - rr) ? rr : p - rr;
            end
        end
        if (!found)
        begin
            r.st = ST_NO_NQR;
            return r;
        end
        ip = isqrt(p);
        hi = p;
        lo = x;
        while (lo > ip)
        begin
            rem = hi % lo;
            hi  = lo;
            lo  = rem;
        end
        a = lo;
        b = isqrt(p - a * a);
        if (a * a + b * b != p)
        begin
            r.st = ST_CHECK;
            return r;
        end
        r.a = a[ROOT_W-1:0];
        r.b = b[ROOT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit is_prime(longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 0;
        if (n % 2 == 0)
            return n == 2;
        for (d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    // random prime = 1 mod 4, of random size
    function automatic logic [PRIME_W-1:0] random_prime();
        int              w;
        longint unsigned v;
        w = $urandom_range(100) < 70 ? $urandom_range(4, 32) : 32;
        do
        begin
            v = {$urandom} & ((64'd1 << w) - 1);
            v = (v & ~64'd3) | 64'd1;
        end while (!is_prime(v));
        return v[PRIME_W-1:0];
    endfunction

    // composites = 1 mod 4 are only sent while max_tries is small
    function automatic logic [PRIME_W-1:0] random_word(bit allow_comp);
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        v    = $urandom;
        if (pick < 25)
        begin
            if (!allow_comp && v[1:0] == 2'b01)
                v[1] = 1'b1;
            return v;
        end
        if (pick < 45 && allow_comp)
        begin
            if ($urandom_range(1))
                v = v >> $urandom_range(31);
            v[1:0] = 2'b01;
            return v;
        end
        return random_prime();
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_primes.size() != 0 || start || busy
               || expected_splits.size() != 0);
        // leave margin after the last answer
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tries(logic [TRY_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_TRIES;
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tries_limit = v;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: hold start until taken, then pop the next word after a gap
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            prime    <= '0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
            start <= 1'b1;
        end
        else
        begin
            if (start)
                expected_splits.push_back(predict_split(prime));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_primes.size() != 0)
            begin
                int g;
                g = $urandom_range(99);
                start    <= 1'b1;
                prime    <= pending_primes.pop_front();
                gap_left <= g < 55 ? 0 : g < 92 ? $urandom_range(1, 4)
                                               : $urandom_range(10, 60);
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each done word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_splits.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
            end
            else
            begin
                split_t e;
                e = expected_splits.pop_front();
                if (first_root != e.a)
                    report("first_root", first_root, e.a);
                if (second_root != e.b)
                    report("second_root", second_root, e.b);
                if (status != e.st)
                    report("status", status, e.st);
            end
        end
    end

    initial
    begin
        #100ms;
        $display("timeout at %0t", $realtime);
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        longint unsigned big;
        errors      = 0;
        tries_limit = MAX_TRIES_RESET;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed primes and wrong residues at the reset setting
        big = 64'hFFFF_FFFD;
        while (!is_prime(big))
            big -= 4;
        pending_primes = '{32'd5, 32'd13, 32'd17, 32'd29, 32'd41, 32'd73,
                           32'd97, 32'd1, 32'd0, 32'd2, 32'd3, 32'd7,
                           32'd4294967291, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                           big[31:0], 32'd65537};
        wait_idle();

        // zero tries: every 1 mod 4 word fails the search
        write_tries(16'd0);
        pending_primes = '{32'd1, 32'd5, 32'd9, 32'hFFFF_FFFD, 32'd6};
        repeat (6) pending_primes.push_back(random_word(1));
        wait_idle();

        // one try: only the first candidate, u = 2 (0 for p = 1), is tested
        write_tries(16'd1);
        pending_primes = '{32'd13, 32'd17, 32'd9, 32'hFFFF_FFFD, 32'd1};
        repeat (20) pending_primes.push_back(random_word(1));
        wait_idle();

        // small limit: composites, candidates past p
        write_tries(16'd16);
        pending_primes = '{32'd9, 32'd21, 32'd25, 32'd65, 32'd45, 32'd5};
        repeat (30) pending_primes.push_back(random_word(1));
        wait_idle();

        // widest limit: primes and wrong residues only
        write_tries(16'hFFFF);
        repeat (40) pending_primes.push_back(random_word(0));
        wait_idle();

        write_tries(MAX_TRIES_RESET);
        repeat (40) pending_primes.push_back(random_word(0));
        wait_idle();

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
